// File: hdl/kivm_pkg.sv
package kivm_pkg;

    localparam int ELEM_BITS     = 31;
    localparam int MAX_DIM_DEF   = 64;
    localparam int LEN_BITS      = 7;
    localparam int CNT_BITS      = 16;
    localparam int IDX_BITS      = 6;
    localparam logic [ELEM_BITS-1:0] PRIME_RESET = ELEM_BITS'(131071);
    localparam logic [LEN_BITS-1:0]  LEN_RESET   = LEN_BITS'(64);
    localparam logic [CNT_BITS-1:0]  COUNT_RESET = CNT_BITS'(1);

    typedef enum logic [1:0] {
        OP_LOAD_MATRIX = 2'd0,
        OP_LOAD_VECTOR = 2'd1,
        OP_STEP        = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_VECTOR_LENGTH = 2'd0,
        REG_PRIME_MODULUS = 2'd1,
        REG_ITERATE_COUNT = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_CALC,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [IDX_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  column;
        logic [ELEM_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]  iterate_index;
        logic [IDX_BITS-1:0]  element_index;
        logic [ELEM_BITS-1:0] element_value;
        logic                 last_of_run;
    } result_t;

endpackage

// File: hdl/kivm_mulmod.sv
module kivm_mulmod
    import kivm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ELEM_BITS-1:0] a,
    input  logic [ELEM_BITS-1:0] b,
    input  logic [ELEM_BITS-1:0] c,
    input  logic [ELEM_BITS-1:0] p,
    output logic                 running,
    output logic                 done,
    output logic [ELEM_BITS-1:0] result
);

    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int PW        = PROD_BITS + 1;
    localparam int CW        = $clog2(PW + 1);

    logic [PROD_BITS-1:0] mul_w;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [ELEM_BITS-1:0] rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [ELEM_BITS:0]   trial;

    assign mul_w = PROD_BITS'(a) * PROD_BITS'(b);
    assign trial = {rem_reg, prod_reg[PW-1]};

    // Restoring remainder: one product bit is shifted in per cycle.
    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = PW'(mul_w) + PW'(c);
            rem_next  = '0;
            cnt_next  = CW'(PW);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            if (trial >= {1'b0, p})
                rem_next = ELEM_BITS'(trial - {1'b0, p});
            else
                rem_next = ELEM_BITS'(trial);
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign running = run_reg;
    assign done    = done_reg;
    assign result  = rem_reg;

endmodule

// File: hdl/krylov_iterate_vector_mod_prime.sv
// A load starts the unit, runs 63 remainder steps and then stores the result.
// A step feeds each of the n*n matrix products (n = vector length) through the single serial
// multiply-modulo unit; results stream out one beat per row as each row finishes.
// A load or a step that does nothing never raises busy; the next command can follow at once.
// Reset clears control state and sets the registers to n = 64, p = 131071, d = 1.
// Results come as strobed beats; the receiver cannot stall.
module krylov_iterate_vector_mod_prime
    import kivm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [ELEM_BITS-1:0] cfg_data,
    output logic                 result_valid,
    output result_t              result
);

    localparam int DAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MAW = 2 * DAW;
    localparam int VAW = DAW + 1;

    logic [LEN_BITS-1:0]  len_reg;
    logic [ELEM_BITS-1:0] prime_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  done_cnt_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [DAW-1:0]       i_reg, j_reg;
    logic                 bank_reg;
    logic [ELEM_BITS-1:0] acc_reg;

    logic [ELEM_BITS-1:0] mat_mem [2**MAW];
    logic [ELEM_BITS-1:0] vec_mem [2**VAW];
    logic [ELEM_BITS-1:0] mat_rd_reg, vec_rd_reg;

    logic [LEN_BITS-1:0]  n_use, n_m1;
    logic [ELEM_BITS-1:0] p_use;
    logic [CNT_BITS-1:0]  d_use;
    logic                 accept, can_step, load_ok;
    logic                 unit_start, unit_running, unit_done;
    logic [ELEM_BITS-1:0] unit_a, unit_b, unit_c, unit_res;
    logic                 last_j, last_i, is_load;

    assign n_use = (len_reg == '0) ? LEN_BITS'(1)
                 : (len_reg > LEN_BITS'(MAX_DIM)) ? LEN_BITS'(MAX_DIM) : len_reg;
    assign n_m1  = n_use - LEN_BITS'(1);
    assign p_use = (prime_reg < ELEM_BITS'(2)) ? ELEM_BITS'(2) : prime_reg;
    assign d_use = (count_reg == '0) ? CNT_BITS'(1) : count_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign can_step  = ({1'b0, done_cnt_reg} + 17'd1) < {1'b0, d_use};
    assign last_j    = (LEN_BITS'(j_reg) == n_m1);
    assign last_i    = (LEN_BITS'(i_reg) == n_m1);
    assign is_load   = (cmd_reg.opcode != OP_STEP);

    always_comb
    begin
        case (cmd.opcode)
            OP_LOAD_MATRIX: load_ok = (LEN_BITS'(cmd.row) < n_use)
                                   && (LEN_BITS'(cmd.column) < n_use);
            OP_LOAD_VECTOR: load_ok = (LEN_BITS'(cmd.row) < n_use);
            default:        load_ok = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && load_ok)
                    state_next = ST_LOAD;
                else if (accept && cmd.opcode == OP_STEP && can_step)
                    state_next = ST_READ;
            end
            ST_LOAD: state_next = ST_WAIT;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    if (is_load || (last_j && last_i))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs to the shared unit.
    always_comb
    begin
        unit_start = 1'b0;
        unit_a     = mat_rd_reg;
        unit_b     = vec_rd_reg;
        unit_c     = acc_reg;
        case (state_reg)
            ST_LOAD:
            begin
                unit_start = 1'b1;
                unit_a     = cmd_reg.value;
                unit_b     = ELEM_BITS'(1);
                unit_c     = '0;
            end
            ST_CALC: unit_start = 1'b1;
            default: unit_start = 1'b0;
        endcase
    end

    kivm_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .a       (unit_a),
        .b       (unit_b),
        .c       (unit_c),
        .p       (p_use),
        .running (unit_running),
        .done    (unit_done),
        .result  (unit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= LEN_RESET;
            prime_reg    <= PRIME_RESET;
            count_reg    <= COUNT_RESET;
            done_cnt_reg <= '0;
            bank_reg     <= 1'b0;
            result_valid <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VECTOR_LENGTH: len_reg   <= cfg_data[LEN_BITS-1:0];
                    REG_PRIME_MODULUS: prime_reg <= cfg_data;
                    REG_ITERATE_COUNT: count_reg <= cfg_data[CNT_BITS-1:0];
                    default:           ;
                endcase
            end
            if (state_reg == ST_IDLE)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (state_reg == ST_WAIT && unit_done)
            begin
                if (is_load)
                begin
                    if (cmd_reg.opcode == OP_LOAD_VECTOR)
                        done_cnt_reg <= '0;
                end
                else if (last_j)
                begin
                    result_valid <= 1'b1;
                    j_reg        <= '0;
                    i_reg        <= i_reg + DAW'(1);
                    if (last_i)
                    begin
                        bank_reg     <= ~bank_reg;
                        done_cnt_reg <= done_cnt_reg + CNT_BITS'(1);
                    end
                end
                else
                    j_reg <= j_reg + DAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (state_reg == ST_IDLE)
            acc_reg <= '0;
        else if (state_reg == ST_WAIT && unit_done)
            acc_reg <= last_j ? '0 : unit_res;
        if (state_reg == ST_WAIT && unit_done && !is_load && last_j)
        begin
            result.iterate_index <= done_cnt_reg + CNT_BITS'(1);
            result.element_index <= IDX_BITS'(i_reg);
            result.element_value <= unit_res;
            result.last_of_run   <= last_i;
        end
    end

    // Matrix and vector stores; the vector store holds two banks, current and next.
    always_ff @(posedge clk)
    begin
        mat_rd_reg <= mat_mem[{i_reg, j_reg}];
        vec_rd_reg <= vec_mem[{bank_reg, j_reg}];
        if (state_reg == ST_WAIT && unit_done)
        begin
            if (cmd_reg.opcode == OP_LOAD_MATRIX)
                mat_mem[{cmd_reg.row[DAW-1:0], cmd_reg.column[DAW-1:0]}] <= unit_res;
            else if (cmd_reg.opcode == OP_LOAD_VECTOR)
                vec_mem[{bank_reg, cmd_reg.row[DAW-1:0]}] <= unit_res;
            else if (last_j)
                vec_mem[{~bank_reg, i_reg}] <= unit_res;
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> state_reg == ST_WAIT)
        else $error("multiply unit finished outside the wait state");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_WAIT) && $past(!is_load))
        else $error("result beat without a finished row");

    a_result_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result beats in adjacent cycles");

    a_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        unit_running |-> busy)
        else $error("multiply unit running while the block is idle");

endmodule
